// ----- sv/ggn_pkg.sv -----
// Shared constants and types for the grid neighbourhood block.
package ggn_pkg;

   // Fixed field widths of the request and result channels.
   localparam int CELL_W     = 23;
   localparam int POS_W      = 6;
   localparam int RADIUS_W   = 2;
   localparam int CAP_W      = 6;
   localparam int COORD_W    = 32;
   // Offset coordinate sums carry two extra bits for sign and headroom.
   localparam int SUM_W      = 34;
   // Dividends of the row and column divisions are non-negative and below 2^32.
   localparam int DIVIDEND_W = 32;

   // Spans in degrees times 1e7.
   localparam logic [63:0] LAT_SPAN = 64'd900000000;
   localparam logic [63:0] LON_SPAN = 64'd3600000000;
   localparam logic [63:0] LON_HALF = LON_SPAN / 2;

   // One result as it leaves the neighbour walker.
   typedef struct packed {
      logic              strobe;
      logic [CELL_W-1:0] cell_index;
      logic [POS_W-1:0]  position;
      logic              last;
   } ggn_rsp_type;

endpackage

// ----- sv/geo_grid_neighbourhood_top.sv -----
// Top level of the grid neighbourhood block: setup sequencer, divider and walker.
// The first result follows the request transfer after two divisions, each with its start
// state, then a plan state and the walker's multiply and centre states.
// One request at a time: busy stays high until the last result has been given, and a
// request with zero capacity gives the single empty result.
// Synchronous active-high reset clears all control state; results never stall.
module geo_grid_neighbourhood_top import ggn_pkg::*; #(
   parameter int CELL_SIZE_E7 = 1000000,
   parameter int GRID_ROWS    = 1800,
   parameter int GRID_COLUMNS = 3600,
   parameter int MAX_RADIUS   = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_latitude,
   input  logic signed [COORD_W-1:0] req_longitude,
   input  logic [RADIUS_W-1:0]       req_radius,
   input  logic [CAP_W-1:0]          req_capacity,
   output logic                      rsp_valid,
   output logic [CELL_W-1:0]         rsp_cell_res,
   output logic [POS_W-1:0]          rsp_position,
   output logic                      rsp_last,
   output logic                      rsp_empty_res
);

   localparam int ROW_W = $clog2(GRID_ROWS);
   localparam int COL_W = $clog2(GRID_COLUMNS);
   localparam int QBITS = $clog2(LON_SPAN / 64'(CELL_SIZE_E7) + 64'd1);

   typedef enum logic [2:0] {
      T_IDLE, T_EMPTY, T_LAT_START, T_LAT_WAIT, T_LON_START, T_LON_WAIT, T_PLAN, T_WALK
   } top_state_type;

   top_state_type         state_ff;
   logic [SUM_W-1:0]      lat_sum_ff;
   logic [SUM_W-1:0]      lon_sum_ff;
   logic [RADIUS_W-1:0]   radius_ff;
   logic [CAP_W-1:0]      cap_ff;
   logic [ROW_W-1:0]      crow_ff;
   logic [COL_W-1:0]      ccol_ff;
   logic                  empty_ff;

   logic                  accept_in;
   logic [RADIUS_W-1:0]   radius_in;
   logic [2:0]            side_in;
   logic [CAP_W-1:0]      square_in;
   logic [CAP_W-1:0]      cap_in;
   logic [SUM_W-1:0]      lon_wrap_in;
   logic [DIVIDEND_W-1:0] dividend_in;
   logic                  div_start_in;
   logic                  div_done;
   logic [QBITS-1:0]      quotient;
   logic [2:0]            side_ff_in;
   logic [ROW_W-1:0]      row_lo_in;
   logic [ROW_W-1:0]      row_hi_in;
   logic [2:0]            nrows_in;
   logic [CAP_W-1:0]      cells_in;
   logic [POS_W-1:0]      total_in;
   logic                  walk_start_in;
   ggn_rsp_type           walk_rsp;

   // Request transfer and saturation of radius and capacity.
   assign accept_in = start && !busy;
   assign radius_in = (32'(req_radius) > 32'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : req_radius;
   assign side_in   = {radius_in, 1'b1};
   assign square_in = CAP_W'(side_in) * CAP_W'(side_in);
   assign cap_in    = (req_capacity > square_in) ? square_in : req_capacity;

   // Row dividend clamps at the south pole; column dividend wraps into one world span.
   assign lon_wrap_in = lon_sum_ff[SUM_W-1] ? (lon_sum_ff + SUM_W'(LON_SPAN)) :
                        (lon_sum_ff >= SUM_W'(LON_SPAN)) ? (lon_sum_ff - SUM_W'(LON_SPAN)) :
                        lon_sum_ff;
   assign dividend_in  = (state_ff == T_LAT_START) ?
                         (lat_sum_ff[SUM_W-1] ? '0 : lat_sum_ff[DIVIDEND_W-1:0]) :
                         lon_wrap_in[DIVIDEND_W-1:0];
   assign div_start_in = (state_ff == T_LAT_START) || (state_ff == T_LON_START);

   ggn_divider #(
      .DIVISOR (CELL_SIZE_E7),
      .QBITS   (QBITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_in),
      .dividend (dividend_in),
      .done     (div_done),
      .quotient (quotient)
   );

   // Rows of the square that lie on the grid, and how many cells can be given.
   assign side_ff_in = {radius_ff, 1'b1};
   assign row_lo_in  = (crow_ff >= ROW_W'(radius_ff)) ? (crow_ff - ROW_W'(radius_ff)) : '0;
   assign row_hi_in  = (32'(crow_ff) + 32'(radius_ff) > 32'(GRID_ROWS - 1)) ?
                       ROW_W'(GRID_ROWS - 1) : (crow_ff + ROW_W'(radius_ff));
   assign nrows_in   = 3'(row_hi_in - row_lo_in) + 3'd1;
   assign cells_in   = CAP_W'(nrows_in) * CAP_W'(side_ff_in);
   assign total_in   = POS_W'((cap_ff > cells_in) ? cells_in : cap_ff);
   assign walk_start_in = (state_ff == T_PLAN);

   ggn_walker #(
      .GRID_ROWS    (GRID_ROWS),
      .GRID_COLUMNS (GRID_COLUMNS)
   ) u_walker (
      .clock         (clock),
      .reset         (reset),
      .start         (walk_start_in),
      .centre_row    (crow_ff),
      .centre_column (ccol_ff),
      .row_low       (row_lo_in),
      .radius        (radius_ff),
      .total         (total_in),
      .rsp           (walk_rsp)
   );

   // Setup sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         empty_ff <= 1'b0;
      end else begin
         empty_ff <= 1'b0;
         unique case (state_ff)
            T_IDLE: begin
               if (accept_in) begin
                  lat_sum_ff <= SUM_W'(req_latitude) + SUM_W'(LAT_SPAN);
                  lon_sum_ff <= SUM_W'(req_longitude) + SUM_W'(LON_HALF);
                  radius_ff  <= radius_in;
                  cap_ff     <= cap_in;
                  if (cap_in == '0) begin
                     empty_ff <= 1'b1;
                     state_ff <= T_EMPTY;
                  end else begin
                     state_ff <= T_LAT_START;
                  end
               end
            end
            T_EMPTY: begin
               state_ff <= T_IDLE;
            end
            T_LAT_START: begin
               state_ff <= T_LAT_WAIT;
            end
            T_LAT_WAIT: begin
               if (div_done) begin
                  crow_ff  <= (32'(quotient) >= 32'(GRID_ROWS)) ?
                              ROW_W'(GRID_ROWS - 1) : ROW_W'(quotient);
                  state_ff <= T_LON_START;
               end
            end
            T_LON_START: begin
               state_ff <= T_LON_WAIT;
            end
            T_LON_WAIT: begin
               if (div_done) begin
                  ccol_ff  <= (32'(quotient) >= 32'(GRID_COLUMNS)) ?
                              COL_W'(GRID_COLUMNS - 1) : COL_W'(quotient);
                  state_ff <= T_PLAN;
               end
            end
            T_PLAN: begin
               state_ff <= T_WALK;
            end
            T_WALK: begin
               if (walk_rsp.strobe && walk_rsp.last) begin
                  state_ff <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   // Result ports: the walker's results, or the single empty result.
   assign busy          = (state_ff != T_IDLE);
   assign rsp_valid     = walk_rsp.strobe || empty_ff;
   assign rsp_cell_res  = empty_ff ? '0 : walk_rsp.cell_index;
   assign rsp_position  = empty_ff ? '0 : walk_rsp.position;
   assign rsp_last      = empty_ff || walk_rsp.last;
   assign rsp_empty_res = empty_ff;

endmodule

// ----- sv/ggn_divider.sv -----
// Divider by a fixed cell size: reciprocal multiplication on one shared 32x17 multiplier.
module ggn_divider import ggn_pkg::*; #(
   parameter int DIVISOR = 1000000,
   parameter int QBITS   = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic                  done,
   output logic [QBITS-1:0]      quotient
);

   // The reciprocal ceil(2^SHIFT / DIVISOR) with SHIFT = DIVIDEND_W + clog2(DIVISOR) gives
   // the exact quotient for every dividend below 2^DIVIDEND_W; it needs DIVIDEND_W+1 bits.
   localparam int              SHIFT = DIVIDEND_W + $clog2(DIVISOR);
   localparam logic [63:0]     RECIP =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam int              LO_W  = 16;
   localparam int              HI_W  = DIVIDEND_W + 1 - LO_W;
   localparam int              MUL_W = DIVIDEND_W + HI_W;
   localparam int              ACC_W = DIVIDEND_W + DIVIDEND_W + 1;
   localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
   localparam logic [HI_W-1:0] RECIP_HI = RECIP[DIVIDEND_W:LO_W];

   logic [DIVIDEND_W-1:0] num_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic                  run_ff;
   logic                  high_ff;
   logic                  done_ff;
   logic [HI_W-1:0]       mul_b_in;
   logic [MUL_W-1:0]      mul_in;

   // The shared multiplier takes the low half of the reciprocal first, the high half next.
   assign mul_b_in = high_ff ? RECIP_HI : HI_W'(RECIP_LO);
   assign mul_in   = MUL_W'(num_ff) * MUL_W'(mul_b_in);

   // Load, then accumulate the low partial product and after it the shifted high one.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         high_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= dividend;
            high_ff <= 1'b0;
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            if (!high_ff) begin
               acc_ff  <= ACC_W'(mul_in);
               high_ff <= 1'b1;
            end else begin
               acc_ff  <= acc_ff + {mul_in, LO_W'(0)};
               high_ff <= 1'b0;
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = acc_ff[SHIFT +: QBITS];

endmodule

// ----- sv/ggn_walker.sv -----
// Neighbour walker: emits the centre cell, then the square of cells row by row.
module ggn_walker import ggn_pkg::*; #(
   parameter int GRID_ROWS    = 1800,
   parameter int GRID_COLUMNS = 3600
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [$clog2(GRID_ROWS)-1:0]    centre_row,
   input  logic [$clog2(GRID_COLUMNS)-1:0] centre_column,
   input  logic [$clog2(GRID_ROWS)-1:0]    row_low,
   input  logic [RADIUS_W-1:0]           radius,
   input  logic [POS_W-1:0]              total,
   output ggn_rsp_type                   rsp
);

   localparam int ROW_W = $clog2(GRID_ROWS);
   localparam int COL_W = $clog2(GRID_COLUMNS);

   typedef enum logic [1:0] {W_IDLE, W_MUL, W_CENTRE, W_SCAN} walk_state_type;

   walk_state_type        state_ff;
   ggn_rsp_type           rsp_ff;
   logic [ROW_W-1:0]      crow_ff;
   logic [COL_W-1:0]      ccol_ff;
   logic [ROW_W-1:0]      row_lo_ff;
   logic [RADIUS_W-1:0]   radius_ff;
   logic [POS_W-1:0]      total_ff;
   logic [CELL_W-1:0]     prod_ff;
   logic [COL_W-1:0]      col_start_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [CELL_W-1:0]     row_base_ff;
   logic [COL_W-1:0]      col_ff;
   logic [2:0]            dc_ff;
   logic [POS_W-1:0]      count_ff;

   logic [ROW_W-1:0]      mul_a_in;
   logic [CELL_W-1:0]     mul_in;
   logic [COL_W-1:0]      col_start_in;
   logic [2:0]            dc_end_in;
   logic                  is_centre_in;
   logic                  is_last_in;

   // The single multiplier serves the centre row first and the lowest row next.
   assign mul_a_in = (state_ff == W_MUL) ? crow_ff : row_lo_ff;
   assign mul_in   = CELL_W'(32'(mul_a_in) * 32'(GRID_COLUMNS));

   // Leftmost column of the square, wrapped at the dateline.
   assign col_start_in = (ccol_ff >= COL_W'(radius_ff)) ?
      (ccol_ff - COL_W'(radius_ff)) :
      COL_W'({1'b0, ccol_ff} + (COL_W+1)'(GRID_COLUMNS) - (COL_W+1)'(radius_ff));

   // Scan position tests. The cells of one square never alias, so no duplicate check is needed.
   assign dc_end_in    = {radius_ff, 1'b0};
   assign is_centre_in = (row_ff == crow_ff) && (dc_ff == 3'(radius_ff));
   assign is_last_in   = (count_ff + POS_W'(1)) == total_ff;

   // Sequencer with its registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= W_IDLE;
         rsp_ff.strobe <= 1'b0;
      end else begin
         rsp_ff.strobe <= 1'b0;
         unique case (state_ff)
            W_IDLE: begin
               if (start) begin
                  crow_ff   <= centre_row;
                  ccol_ff   <= centre_column;
                  row_lo_ff <= row_low;
                  radius_ff <= radius;
                  total_ff  <= total;
                  state_ff  <= W_MUL;
               end
            end
            W_MUL: begin
               prod_ff      <= mul_in;
               col_start_ff <= col_start_in;
               state_ff     <= W_CENTRE;
            end
            W_CENTRE: begin
               rsp_ff.strobe     <= 1'b1;
               rsp_ff.cell_index <= prod_ff + CELL_W'(ccol_ff);
               rsp_ff.position   <= '0;
               rsp_ff.last       <= (total_ff == POS_W'(1));
               row_base_ff       <= mul_in;
               row_ff            <= row_lo_ff;
               col_ff            <= col_start_ff;
               dc_ff             <= '0;
               count_ff          <= POS_W'(1);
               state_ff          <= (total_ff == POS_W'(1)) ? W_IDLE : W_SCAN;
            end
            W_SCAN: begin
               // Emit each cell of the square except the centre, until the total is reached.
               if (!is_centre_in) begin
                  rsp_ff.strobe     <= 1'b1;
                  rsp_ff.cell_index <= row_base_ff + CELL_W'(col_ff);
                  rsp_ff.position   <= count_ff;
                  rsp_ff.last       <= is_last_in;
                  count_ff          <= count_ff + POS_W'(1);
                  if (is_last_in) begin
                     state_ff <= W_IDLE;
                  end
               end
               // Advance along the row, wrapping the column, then to the next row.
               if (dc_ff == dc_end_in) begin
                  dc_ff       <= '0;
                  row_ff      <= row_ff + ROW_W'(1);
                  row_base_ff <= row_base_ff + CELL_W'(GRID_COLUMNS);
                  col_ff      <= col_start_ff;
               end else begin
                  dc_ff  <= dc_ff + 3'd1;
                  col_ff <= (col_ff == COL_W'(GRID_COLUMNS - 1)) ? '0 : col_ff + COL_W'(1);
               end
            end
            default: begin
               state_ff <= W_IDLE;
            end
         endcase
      end
   end

   assign rsp = rsp_ff;

endmodule
